// ----- rtl/srg_pkg.sv -----
package srg_pkg;

	localparam int TABLE_LEN        = 55;
	localparam int STRIDE           = 21;
	localparam int SECOND_START     = 24;
	localparam int LAST_INDEX       = 54;
	localparam int IDX_W            = 6;
	localparam int MOD_W            = 30;
	localparam int OUT_W            = 30;
	localparam int SEED_W           = 32;
	localparam int DIV_STEPS        = 32;
	localparam int FILL_STEPS       = 54;
	localparam int WARMUP_DRAWS_DEF = 165;
	localparam int VALUE_BITS_DEF   = 30;

	localparam logic [MOD_W-1:0] MOD_RESET = 30'd1000000007;

	localparam logic ACTION_SEED = 1'b0;
	localparam logic ACTION_DRAW = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_FIX,
		ST_FILL,
		ST_WARM
	} srg_state_t;

	typedef struct packed {
		logic div_start;
		logic div_step;
		logic fix;
		logic fill_step;
		logic draw;
		logic emit;
	} srg_cmd_t;

	typedef struct packed {
		logic room;
	} srg_sts_t;

endpackage

// ----- rtl/srg_ram.sv -----
module srg_ram #(
	parameter int WIDTH = 30,
	parameter int DEPTH = 55
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_a_q;
	logic [WIDTH-1:0] rd_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_a_q <= mem_q[raddr_a];
		rd_b_q <= mem_q[raddr_b];
	end

	assign rdata_a = rd_a_q;
	assign rdata_b = rd_b_q;

endmodule

// ----- rtl/srg_ctrl.sv -----
module srg_ctrl #(
	parameter int WARMUP_DRAWS = srg_pkg::WARMUP_DRAWS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             action,
	input  srg_pkg::srg_sts_t sts,
	output srg_pkg::srg_cmd_t cmd
);

	localparam int WARM_CW = $clog2(WARMUP_DRAWS + 1);
	localparam int CNT_W   = (WARM_CW > 6) ? WARM_CW : 6;

	srg_pkg::srg_state_t state_q, state_d;
	logic [CNT_W-1:0]    cnt_q, cnt_d;
	logic                idle_room;
	logic                accept;

	assign idle_room = (state_q == srg_pkg::ST_IDLE) && sts.room;
	assign accept    = in_valid && idle_room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srg_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		unique case (state_q)
			srg_pkg::ST_IDLE: begin
				if (accept && (action == srg_pkg::ACTION_SEED)) begin
					state_d = srg_pkg::ST_DIV;
					cnt_d   = CNT_W'(srg_pkg::DIV_STEPS - 1);
				end
			end
			srg_pkg::ST_DIV: begin
				if (cnt_q == '0) begin
					state_d = srg_pkg::ST_FIX;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			srg_pkg::ST_FIX: begin
				state_d = srg_pkg::ST_FILL;
				cnt_d   = CNT_W'(srg_pkg::FILL_STEPS - 1);
			end
			srg_pkg::ST_FILL: begin
				if (cnt_q == '0) begin
					if (WARMUP_DRAWS == 0) begin
						state_d = srg_pkg::ST_IDLE;
					end else begin
						state_d = srg_pkg::ST_WARM;
						cnt_d   = CNT_W'(WARMUP_DRAWS - 1);
					end
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			srg_pkg::ST_WARM: begin
				if (cnt_q == '0) begin
					state_d = srg_pkg::ST_IDLE;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			default: begin
				state_d = srg_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			srg_pkg::ST_IDLE: begin
				in_ready      = idle_room;
				cmd.div_start = accept && (action == srg_pkg::ACTION_SEED);
				cmd.draw      = accept && (action == srg_pkg::ACTION_DRAW);
				cmd.emit      = accept && (action == srg_pkg::ACTION_DRAW);
			end
			srg_pkg::ST_DIV:  cmd.div_step  = 1'b1;
			srg_pkg::ST_FIX:  cmd.fix       = 1'b1;
			srg_pkg::ST_FILL: cmd.fill_step = 1'b1;
			srg_pkg::ST_WARM: cmd.draw      = 1'b1;
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ----- rtl/srg_dp.sv -----
module srg_dp #(
	parameter int VALUE_BITS = srg_pkg::VALUE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  srg_pkg::srg_cmd_t                 cmd,
	output srg_pkg::srg_sts_t                 sts,
	input  logic signed [srg_pkg::SEED_W-1:0] seed_value,
	input  logic                              modulus_wr_en,
	input  logic [srg_pkg::MOD_W-1:0]         modulus_wr_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [srg_pkg::OUT_W-1:0]         random_value
);

	localparam int VB   = VALUE_BITS;
	localparam int MW   = srg_pkg::MOD_W;
	localparam int WIDE = (VB > MW) ? VB : MW;
	localparam int SW   = WIDE + 2;
	localparam int IW   = srg_pkg::IDX_W;
	localparam int OW   = srg_pkg::OUT_W;
	localparam int SDW  = srg_pkg::SEED_W;
	localparam int LEN  = srg_pkg::TABLE_LEN;

	function automatic logic [IW-1:0] step_back(input logic [IW-1:0] p);
		if ((p == '0) || (p > IW'(srg_pkg::LAST_INDEX))) begin
			return IW'(srg_pkg::LAST_INDEX);
		end
		return p - 1'b1;
	endfunction

	// modulus register and effective modulus
	logic [MW-1:0] modulus_q;
	logic [MW-1:0] m_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= srg_pkg::MOD_RESET;
		end else if (modulus_wr_en) begin
			modulus_q <= modulus_wr_data;
		end
	end

	assign m_eff = (modulus_q < MW'(2)) ? MW'(2) : modulus_q;

	// restoring remainder of |seed|, one bit per cycle
	logic [SDW-1:0] seed_u;
	logic [SDW-1:0] seed_abs;
	logic [SDW-1:0] div_q;
	logic [MW-1:0]  rem_q;
	logic           neg_q;
	logic [MW:0]    trial;
	logic [MW:0]    trial_sub;
	logic [MW-1:0]  rem_next;
	logic [MW-1:0]  reduced;
	logic [VB-1:0]  seed_val;

	assign seed_u    = seed_value;
	assign seed_abs  = seed_u[SDW-1] ? (~seed_u + 1'b1) : seed_u;
	assign trial     = {rem_q, div_q[SDW-1]};
	assign trial_sub = trial - {1'b0, m_eff};
	assign rem_next  = (trial >= {1'b0, m_eff}) ? trial_sub[MW-1:0] : trial[MW-1:0];
	// negative seed: remainder folds back into range
	assign reduced   = (neg_q && (rem_q != '0)) ? (m_eff - rem_q) : rem_q;
	assign seed_val  = VB'(reduced);

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			div_q <= seed_abs;
			rem_q <= '0;
			neg_q <= seed_u[SDW-1];
		end else if (cmd.div_step) begin
			div_q <= div_q << 1;
			rem_q <= rem_next;
		end
	end

	// table ram with per-entry valid flags
	logic [LEN-1:0] valid_q;
	logic           we;
	logic [IW-1:0]  waddr;
	logic [VB-1:0]  wdata;
	logic [IW-1:0]  raddr_a;
	logic [IW-1:0]  raddr_b;
	logic [VB-1:0]  rdata_a;
	logic [VB-1:0]  rdata_b;
	logic           vld_a_s1;
	logic           vld_b_s1;
	logic           s1_valid_q;
	logic           s1_emit_q;
	logic [IW-1:0]  ptr_a_q;
	logic [IW-1:0]  ptr_b_q;

	srg_ram #(
		.WIDTH(VB),
		.DEPTH(LEN)
	) u_ram (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	assign raddr_a = step_back(ptr_a_q);
	assign raddr_b = step_back(ptr_b_q);

	// shared subtract-and-wrap unit
	logic [VB-1:0] op_x;
	logic [VB-1:0] op_y;
	logic [SW-1:0] diff;
	logic [SW-1:0] sum;
	logic [VB-1:0] sub_res;
	logic [VB-1:0] last_q;
	logic [VB-1:0] next_q;

	always_comb begin
		if (cmd.fill_step) begin
			op_x = last_q;
			op_y = next_q;
		end else begin
			op_x = vld_a_s1 ? rdata_a : '0;
			op_y = vld_b_s1 ? rdata_b : '0;
		end
	end

	assign diff    = SW'(op_x) - SW'(op_y);
	assign sum     = diff + SW'(m_eff);
	assign sub_res = diff[SW-1] ? sum[VB-1:0] : diff[VB-1:0];

	// fill sequencing
	logic [IW-1:0] pos_q;
	logic [IW:0]   pos_sum;
	logic [IW:0]   pos_wrap;

	assign pos_sum  = {1'b0, pos_q} + (IW+1)'(srg_pkg::STRIDE);
	assign pos_wrap = (pos_sum >= (IW+1)'(LEN)) ? (pos_sum - (IW+1)'(LEN)) : pos_sum;

	always_ff @(posedge clk) begin
		if (cmd.fix) begin
			last_q <= seed_val;
			next_q <= VB'(1);
			pos_q  <= IW'(srg_pkg::STRIDE);
		end else if (cmd.fill_step) begin
			last_q <= next_q;
			next_q <= sub_res;
			pos_q  <= pos_wrap[IW-1:0];
		end
	end

	always_comb begin
		we    = 1'b0;
		waddr = ptr_a_q;
		wdata = sub_res;
		if (s1_valid_q) begin
			we = 1'b1;
		end else if (cmd.fix) begin
			we    = 1'b1;
			waddr = '0;
			wdata = seed_val;
		end else if (cmd.fill_step) begin
			we    = 1'b1;
			waddr = pos_q;
			wdata = next_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			s1_valid_q <= 1'b0;
			s1_emit_q  <= 1'b0;
			ptr_a_q    <= '0;
			ptr_b_q    <= IW'(srg_pkg::SECOND_START);
			vld_a_s1   <= 1'b0;
			vld_b_s1   <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			vld_a_s1   <= valid_q[raddr_a];
			vld_b_s1   <= valid_q[raddr_b];
			s1_valid_q <= cmd.draw;
			s1_emit_q  <= cmd.emit;
			if (cmd.fix) begin
				ptr_a_q <= '0;
				ptr_b_q <= IW'(srg_pkg::SECOND_START);
			end else if (cmd.draw) begin
				ptr_a_q <= raddr_a;
				ptr_b_q <= raddr_b;
			end
		end
	end

	// two-entry result buffer
	logic [OW-1:0] ob_q [2];
	logic [1:0]    ob_cnt_q;
	logic          push;
	logic          pop;
	logic [OW-1:0] push_data;
	logic [2:0]    fill_after;

	assign push      = s1_emit_q;
	assign pop       = out_valid && out_ready;
	assign push_data = OW'(sub_res);
	assign out_valid    = (ob_cnt_q != '0);
	assign random_value = ob_q[0];

	// a new draw must find a slot when its beat reaches the buffer
	assign fill_after = {1'b0, ob_cnt_q} + {2'b0, push} - {2'b0, pop};
	assign sts.room   = (fill_after <= 3'd1);

	always_ff @(posedge clk) begin
		case ({push, pop})
			2'b10: begin
				if (ob_cnt_q == 2'd0) begin
					ob_q[0] <= push_data;
				end else begin
					ob_q[1] <= push_data;
				end
			end
			2'b01: begin
				ob_q[0] <= ob_q[1];
			end
			2'b11: begin
				if (ob_cnt_q == 2'd1) begin
					ob_q[0] <= push_data;
				end else begin
					ob_q[0] <= ob_q[1];
					ob_q[1] <= push_data;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_cnt_q <= '0;
		end else begin
			ob_cnt_q <= fill_after[1:0];
		end
	end

endmodule

// ----- rtl/subtractive_random_generator.sv -----
// draw: registered ram read, then result buffer; one draw per cycle while out_ready holds
// seed: no result; a bitwise remainder loop over |seed|, a fix step, 54 fill writes, then
// WARMUP_DRAWS warm-up draws at one per cycle, input held off
// throughput is set by the two-read, one-write table ram and a two-entry result buffer
// reset: table reads as zero through per-entry valid flags, pointers 0 and 24,
// modulus 1000000007
module subtractive_random_generator #(
	parameter int WARMUP_DRAWS = srg_pkg::WARMUP_DRAWS_DEF,
	parameter int VALUE_BITS   = srg_pkg::VALUE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              action,
	input  logic signed [srg_pkg::SEED_W-1:0] seed_value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [srg_pkg::OUT_W-1:0]         random_value,
	input  logic                              modulus_wr_en,
	input  logic [srg_pkg::MOD_W-1:0]         modulus_wr_data
);

	srg_pkg::srg_cmd_t cmd;
	srg_pkg::srg_sts_t sts;

	srg_ctrl #(
		.WARMUP_DRAWS(WARMUP_DRAWS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.action   (action),
		.sts      (sts),
		.cmd      (cmd)
	);

	srg_dp #(
		.VALUE_BITS(VALUE_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.seed_value      (seed_value),
		.modulus_wr_en   (modulus_wr_en),
		.modulus_wr_data (modulus_wr_data),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.random_value    (random_value)
	);

endmodule
